>>> hw/rtl/dhmv_pkg.sv
// shared constants, types and state codes for the digit history majority voter
package dhmv_pkg;

	// history depth and derived widths
	localparam int DEPTH = 16;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	// decimal digit coding
	localparam int DIG_W      = 4;
	localparam int NUM_DIGITS = 10;
	localparam logic [DIG_W-1:0] DIGIT_MAX = DIG_W'(NUM_DIGITS - 1);

	// action codes
	localparam logic ACT_RECORD  = 1'b0;
	localparam logic ACT_RESOLVE = 1'b1;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PICK,
		ST_DONE
	} state_t;

	// tally update from the sequencer to the vote unit
	typedef struct packed {
		logic             clear;
		logic             valid;
		logic [DIG_W-1:0] digit;
	} vote_upd_t;

endpackage

>>> hw/rtl/digit_history_majority_voter.sv
// top level: sequencer around the history ring and the vote unit
//
// Input channel (in_valid / in_stall): action, digit_value, can_increment.
// Output channel (out_valid / out_stall): ok, digit, from_majority, held_count.
// A word moves at a rising edge where valid is high and stall is low.
// A record word with a digit of at most 9 writes the ring at acceptance; its
// result goes through ST_DONE to the output register. A resolve word walks the
// held entries through the ring read port one per cycle, newest first,
// tallying as data returns, then passes ST_PICK and ST_DONE; an empty history
// goes straight to ST_DONE, and with can_increment set only the newest entry is
// read. One word is in work at a time; in_stall is high while a word is in
// work. The output register holds the finished result, so a new word is
// accepted while that result waits; a stalled receiver only stops the block
// when the next result is ready to go out.
// Reset clears the write pointer and fill count (empty history); ring
// contents are not cleared, as only written entries are ever read.
module digit_history_majority_voter (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       action,
	input  logic [dhmv_pkg::DIG_W-1:0] digit_value,
	input  logic                       can_increment,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       ok,
	output logic [dhmv_pkg::DIG_W-1:0] digit,
	output logic                       from_majority,
	output logic [4:0]                 held_count
);

	dhmv_pkg::state_t state_q, state_d;

	logic [dhmv_pkg::PTR_W-1:0] wp_q;
	logic [dhmv_pkg::CNT_W-1:0] fill_q;
	logic [dhmv_pkg::PTR_W-1:0] rd_ptr_q;
	logic [dhmv_pkg::CNT_W-1:0] rd_left_q;
	logic                       rd_vld_s1;
	logic                       newest_pend_q;
	logic [dhmv_pkg::DIG_W-1:0] newest_q;
	logic                       can_inc_q;
	logic                       res_ok_q;
	logic [dhmv_pkg::DIG_W-1:0] res_digit_q;
	logic                       res_maj_q;
	logic                       out_valid_q;
	logic                       ok_q;
	logic [dhmv_pkg::DIG_W-1:0] digit_q;
	logic                       maj_q;
	logic [4:0]                 held_q;

	logic                       accept;
	logic                       rec_ok;
	logic                       wr_en;
	logic                       issue;
	logic                       load_out;
	logic                       majority;
	logic [dhmv_pkg::DIG_W-1:0] rd_data;
	logic [dhmv_pkg::DIG_W-1:0] best_digit;
	logic [dhmv_pkg::CNT_W-1:0] best_count;
	logic [dhmv_pkg::PTR_W-1:0] wp_prev;
	dhmv_pkg::vote_upd_t        upd;

	// ring storage
	dhmv_ram u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wp_q),
		.wr_data (digit_value),
		.rd_en   (issue),
		.rd_addr (rd_ptr_q),
		.rd_data (rd_data)
	);

	// tally unit
	dhmv_vote u_vote (
		.clk        (clk),
		.arst_n     (arst_n),
		.upd        (upd),
		.best_digit (best_digit),
		.best_count (best_count)
	);

	// handshake and datapath controls
	always_comb begin
		accept   = in_valid && (state_q == dhmv_pkg::ST_IDLE);
		rec_ok   = (digit_value <= dhmv_pkg::DIGIT_MAX);
		wr_en    = accept && (action == dhmv_pkg::ACT_RECORD) && rec_ok;
		issue    = (state_q == dhmv_pkg::ST_SCAN) && (rd_left_q != '0);
		load_out = (state_q == dhmv_pkg::ST_DONE) && (!out_valid_q || !out_stall);
		majority = !can_inc_q && ({best_count, 1'b0} > {1'b0, fill_q});
		wp_prev  = (wp_q == '0) ? dhmv_pkg::PTR_W'(dhmv_pkg::DEPTH - 1)
			: wp_q - dhmv_pkg::PTR_W'(1);
		upd.clear = accept && (action == dhmv_pkg::ACT_RESOLVE);
		upd.valid = rd_vld_s1;
		upd.digit = rd_data;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dhmv_pkg::ST_IDLE: begin
				if (accept) begin
					if (action == dhmv_pkg::ACT_RESOLVE && fill_q != '0) begin
						state_d = dhmv_pkg::ST_SCAN;
					end else begin
						state_d = dhmv_pkg::ST_DONE;
					end
				end
			end
			dhmv_pkg::ST_SCAN: begin
				if (rd_left_q == '0 && !rd_vld_s1) begin
					state_d = dhmv_pkg::ST_PICK;
				end
			end
			dhmv_pkg::ST_PICK: begin
				state_d = dhmv_pkg::ST_DONE;
			end
			dhmv_pkg::ST_DONE: begin
				if (load_out) begin
					state_d = dhmv_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dhmv_pkg::ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dhmv_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// history pointer and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
		end else if (wr_en) begin
			wp_q <= (wp_q == dhmv_pkg::PTR_W'(dhmv_pkg::DEPTH - 1)) ? '0
				: wp_q + dhmv_pkg::PTR_W'(1);
			if (fill_q < dhmv_pkg::CNT_W'(dhmv_pkg::DEPTH)) begin
				fill_q <= fill_q + dhmv_pkg::CNT_W'(1);
			end
		end
	end

	// scan control, newest first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_left_q     <= '0;
			rd_vld_s1     <= 1'b0;
			newest_pend_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (upd.clear) begin
				rd_left_q     <= can_increment ? dhmv_pkg::CNT_W'(1) : fill_q;
				newest_pend_q <= 1'b1;
			end else begin
				if (issue) begin
					rd_left_q <= rd_left_q - dhmv_pkg::CNT_W'(1);
				end
				if (rd_vld_s1) begin
					newest_pend_q <= 1'b0;
				end
			end
		end
	end

	// scan address and captured newest entry
	always_ff @(posedge clk) begin
		if (upd.clear) begin
			rd_ptr_q  <= wp_prev;
			can_inc_q <= can_increment;
		end else if (issue) begin
			rd_ptr_q <= (rd_ptr_q == '0) ? dhmv_pkg::PTR_W'(dhmv_pkg::DEPTH - 1)
				: rd_ptr_q - dhmv_pkg::PTR_W'(1);
		end
		if (rd_vld_s1 && newest_pend_q) begin
			newest_q <= rd_data;
		end
	end

	// pending result
	always_ff @(posedge clk) begin
		if (accept) begin
			res_ok_q    <= (action == dhmv_pkg::ACT_RECORD) && rec_ok;
			res_digit_q <= ((action == dhmv_pkg::ACT_RECORD) && rec_ok) ? digit_value : '0;
			res_maj_q   <= 1'b0;
		end else if (state_q == dhmv_pkg::ST_PICK) begin
			res_ok_q    <= 1'b1;
			res_digit_q <= majority ? best_digit : newest_q;
			res_maj_q   <= majority;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			ok_q    <= res_ok_q;
			digit_q <= res_digit_q;
			maj_q   <= res_maj_q;
			held_q  <= 5'(fill_q);
		end
	end

	assign in_stall      = (state_q != dhmv_pkg::ST_IDLE);
	assign out_valid     = out_valid_q;
	assign ok            = ok_q;
	assign digit         = digit_q;
	assign from_majority = maj_q;
	assign held_count    = held_q;

	// checks
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= dhmv_pkg::CNT_W'(dhmv_pkg::DEPTH))
		else $error("fill count beyond depth");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q <= dhmv_pkg::PTR_W'(dhmv_pkg::DEPTH - 1))
		else $error("write pointer beyond depth");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == dhmv_pkg::ST_SCAN))
		else $error("ring read data returned outside scan");

	a_no_write_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != dhmv_pkg::ST_IDLE) |-> !wr_en)
		else $error("ring written while a word is in work");

	a_majority_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && from_majority) |-> ok)
		else $error("majority flag without ok");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !ok) |-> (digit == '0 && !from_majority))
		else $error("rejected word with nonzero digit");

endmodule

>>> hw/rtl/dhmv_ram.sv
// digit history ring storage: one write port, one registered read port
module dhmv_ram (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [dhmv_pkg::PTR_W-1:0] wr_addr,
	input  logic [dhmv_pkg::DIG_W-1:0] wr_data,
	input  logic                      rd_en,
	input  logic [dhmv_pkg::PTR_W-1:0] rd_addr,
	output logic [dhmv_pkg::DIG_W-1:0] rd_data
);

	logic [dhmv_pkg::DIG_W-1:0] mem [dhmv_pkg::DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> hw/rtl/dhmv_vote.sv
// per-digit tally counters with a running mode, lowest digit wins ties
module dhmv_vote (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dhmv_pkg::vote_upd_t        upd,
	output logic [dhmv_pkg::DIG_W-1:0] best_digit,
	output logic [dhmv_pkg::CNT_W-1:0] best_count
);

	logic [dhmv_pkg::CNT_W-1:0] tally_q [dhmv_pkg::NUM_DIGITS];
	logic [dhmv_pkg::DIG_W-1:0] best_q;
	logic [dhmv_pkg::CNT_W-1:0] best_cnt_q;
	logic [dhmv_pkg::CNT_W-1:0] cnt_new;
	logic                       take;
	logic                       lead;

	// new count for the incoming digit and whether it takes the lead
	always_comb begin
		take    = upd.valid && (upd.digit <= dhmv_pkg::DIGIT_MAX);
		cnt_new = take ? tally_q[upd.digit] + dhmv_pkg::CNT_W'(1) : '0;
		lead    = take && ((cnt_new > best_cnt_q) ||
			((cnt_new == best_cnt_q) && (upd.digit < best_q)));
	end

	// tally and running mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < dhmv_pkg::NUM_DIGITS; i++) begin
				tally_q[i] <= '0;
			end
			best_q     <= '0;
			best_cnt_q <= '0;
		end else if (upd.clear) begin
			for (int i = 0; i < dhmv_pkg::NUM_DIGITS; i++) begin
				tally_q[i] <= '0;
			end
			best_q     <= '0;
			best_cnt_q <= '0;
		end else if (take) begin
			tally_q[upd.digit] <= cnt_new;
			if (lead) begin
				best_q     <= upd.digit;
				best_cnt_q <= cnt_new;
			end
		end
	end

	assign best_digit = best_q;
	assign best_count = best_cnt_q;

endmodule
